// File: sv/ffd_pkg.sv
// Shared types and constants for the file frame deframer.
// Used by ffd_front, ffd_queue, ffd_back and file_frame_deframer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffd_pkg;

    // Name length limit applied on top of the configured maximum
    localparam int unsigned NAME_LENGTH_LIMIT = 4096;
    localparam int unsigned NAME_LEN_W        = 13;
    localparam logic [NAME_LEN_W-1:0] NAME_LIMIT_VAL = NAME_LEN_W'(NAME_LENGTH_LIMIT);
    localparam logic [NAME_LEN_W-1:0] MAX_NAME_RESET = NAME_LEN_W'(255);

    // Field widths
    localparam int unsigned TYPE_W = 32;
    localparam int unsigned SIZE_W = 63;
    localparam int unsigned TDATA_OUT_W = 104;

    // Request queue between the parser and the output stage
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    // Input actions
    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_ABORT = 1'b1;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_NAME     = 3'd0,
        KIND_STARTED  = 3'd1,
        KIND_PAYLOAD  = 3'd2,
        KIND_EMPTY    = 3'd3,
        KIND_BAD_LEN  = 3'd4,
        KIND_BAD_SIZE = 3'd5
    } kind_t;

    // One queued request; pair marks a started result that a finished-empty follows
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         byte_value;
        logic               is_last;
        logic [TYPE_W-1:0]  frame_type;
        logic [SIZE_W-1:0]  payload_size;
        logic               pair;
    } entry_t;

endpackage

`default_nettype wire

// File: sv/ffd_front.sv
// Front end: parses the byte stream and turns each byte into at most one request.
// Depends on ffd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffd_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [ffd_pkg::NAME_LEN_W-1:0]     cfg_wr_data,
    input  wire logic                               in_valid,
    input  wire logic                               in_action,
    input  wire logic [7:0]                         in_byte,
    output logic                                    in_ready,
    input  wire logic                               q_full,
    output logic                                    push,
    output ffd_pkg::entry_t                         push_entry
);

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_NAME    = 4'b0010,
        PH_SIZE    = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [2:0]                          idx_reg, idx_next;
    logic [63:0]                         shift_reg, shift_next;
    logic [ffd_pkg::TYPE_W-1:0]          type_reg, type_next;
    logic [ffd_pkg::NAME_LEN_W-1:0]      name_rem_reg, name_rem_next;
    logic [ffd_pkg::SIZE_W-1:0]          pay_rem_reg, pay_rem_next;
    logic [ffd_pkg::NAME_LEN_W-1:0]      max_name_reg;

    logic                                accept;
    logic [ffd_pkg::NAME_LEN_W-1:0]      limit;
    logic [31:0]                         len_word;
    logic [63:0]                         size_full;
    logic                                len_bad;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Effective limit is the smaller of the register and the fixed cap
    assign limit = (max_name_reg > ffd_pkg::NAME_LIMIT_VAL) ? ffd_pkg::NAME_LIMIT_VAL
                                                             : max_name_reg;
    assign len_word  = {in_byte, shift_reg[55:32]};
    assign size_full = {in_byte, shift_reg[55:0]};
    assign len_bad   = (len_word == 32'd0) || len_word[31] ||
                       (len_word > {{(32 - ffd_pkg::NAME_LEN_W){1'b0}}, limit});

    // Parse one byte
    always_comb begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        shift_next    = shift_reg;
        type_next     = type_reg;
        name_rem_next = name_rem_reg;
        pay_rem_next  = pay_rem_reg;
        push          = 1'b0;
        push_entry    = '0;

        if (accept) begin
            if (in_action == ffd_pkg::ACT_ABORT) begin
                phase_next    = PH_HEADER;
                idx_next      = '0;
                shift_next    = '0;
                type_next     = '0;
                name_rem_next = '0;
                pay_rem_next  = '0;
            end else begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        shift_next[idx_reg*8 +: 8] = in_byte;
                        if (idx_reg != 3'd7) begin
                            idx_next = idx_reg + 3'd1;
                        end else if (len_bad) begin
                            push            = 1'b1;
                            push_entry.kind = ffd_pkg::KIND_BAD_LEN;
                            phase_next      = PH_HEADER;
                            idx_next        = '0;
                            shift_next      = '0;
                            type_next       = '0;
                            name_rem_next   = '0;
                            pay_rem_next    = '0;
                        end else begin
                            type_next     = shift_reg[ffd_pkg::TYPE_W-1:0];
                            name_rem_next = len_word[ffd_pkg::NAME_LEN_W-1:0];
                            shift_next    = '0;
                            idx_next      = '0;
                            phase_next    = PH_NAME;
                        end
                    end
                    PH_NAME: begin
                        push                  = 1'b1;
                        push_entry.kind       = ffd_pkg::KIND_NAME;
                        push_entry.byte_value = in_byte;
                        if (name_rem_reg != '0) begin
                            name_rem_next = name_rem_reg - 1'b1;
                        end
                        if (name_rem_reg <= ffd_pkg::NAME_LEN_W'(1)) begin
                            push_entry.is_last = 1'b1;
                            phase_next         = PH_SIZE;
                            shift_next         = '0;
                            idx_next           = '0;
                        end
                    end
                    PH_SIZE: begin
                        shift_next[idx_reg*8 +: 8] = in_byte;
                        if (idx_reg != 3'd7) begin
                            idx_next = idx_reg + 3'd1;
                        end else if (in_byte[7]) begin
                            push            = 1'b1;
                            push_entry.kind = ffd_pkg::KIND_BAD_SIZE;
                            phase_next      = PH_HEADER;
                            idx_next        = '0;
                            shift_next      = '0;
                            type_next       = '0;
                            name_rem_next   = '0;
                            pay_rem_next    = '0;
                        end else begin
                            push                    = 1'b1;
                            push_entry.kind         = ffd_pkg::KIND_STARTED;
                            push_entry.frame_type   = type_reg;
                            push_entry.payload_size = size_full[ffd_pkg::SIZE_W-1:0];
                            shift_next              = '0;
                            idx_next                = '0;
                            if (size_full[ffd_pkg::SIZE_W-1:0] == '0) begin
                                // Empty file: finish at once
                                push_entry.pair = 1'b1;
                                phase_next      = PH_HEADER;
                                type_next       = '0;
                                name_rem_next   = '0;
                                pay_rem_next    = '0;
                            end else begin
                                pay_rem_next = size_full[ffd_pkg::SIZE_W-1:0];
                                phase_next   = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        push                  = 1'b1;
                        push_entry.kind       = ffd_pkg::KIND_PAYLOAD;
                        push_entry.byte_value = in_byte;
                        if (pay_rem_reg != '0) begin
                            pay_rem_next = pay_rem_reg - 1'b1;
                        end
                        if (pay_rem_reg <= ffd_pkg::SIZE_W'(1)) begin
                            push_entry.is_last = 1'b1;
                            phase_next         = PH_HEADER;
                            idx_next           = '0;
                            shift_next         = '0;
                            type_next          = '0;
                            name_rem_next      = '0;
                            pay_rem_next       = '0;
                        end
                    end
                    default: begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    // Hold parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            idx_reg      <= '0;
            shift_reg    <= '0;
            type_reg     <= '0;
            name_rem_reg <= '0;
            pay_rem_reg  <= '0;
        end else begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            shift_reg    <= shift_next;
            type_reg     <= type_next;
            name_rem_reg <= name_rem_next;
            pay_rem_reg  <= pay_rem_next;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_name_reg <= ffd_pkg::MAX_NAME_RESET;
        end else if (cfg_wr_en) begin
            max_name_reg <= cfg_wr_data;
        end
    end

    a_name_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_NAME) |-> (name_rem_reg != '0))
        else $error("name phase with no name bytes left");

    a_payload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (pay_rem_reg != '0))
        else $error("payload phase with no payload bytes left");

    a_idx_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != 3'd0) |-> (phase_reg == PH_HEADER || phase_reg == PH_SIZE))
        else $error("field byte index set outside a field phase");

endmodule

`default_nettype wire

// File: sv/ffd_queue.sv
// Short request queue between the parser and the output stage.
// Depends on ffd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffd_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire ffd_pkg::entry_t    push_entry,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output ffd_pkg::entry_t         head_entry
);

    ffd_pkg::entry_t              mem_reg [ffd_pkg::QDEPTH];
    logic [ffd_pkg::QAW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [ffd_pkg::QCW-1:0]      count_reg, count_next;

    assign full       = (count_reg == ffd_pkg::QCW'(ffd_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store requests
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: sv/ffd_back.sv
// Back end: takes queued requests and drives the result stream register.
// Depends on ffd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffd_back (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   head_valid,
    input  wire ffd_pkg::entry_t                        head_entry,
    output logic                                        pop,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [ffd_pkg::TDATA_OUT_W-1:0]             m_tdata,
    output logic [2:0]                                  m_tuser,
    output logic                                        m_tlast
);

    logic                           m_tvalid_reg;
    ffd_pkg::kind_t                 kind_reg;
    logic [7:0]                     byte_reg;
    logic                           last_reg;
    logic [ffd_pkg::TYPE_W-1:0]     type_reg;
    logic [ffd_pkg::SIZE_W-1:0]     size_reg;
    logic                           pair_half_reg;
    logic                           load;

    assign load = head_valid && (!m_tvalid_reg || m_tready);
    assign pop  = load && (!head_entry.pair || pair_half_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {1'b0, size_reg, type_reg, byte_reg};

    // Valid flag and pair tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg  <= 1'b0;
            pair_half_reg <= 1'b0;
        end else begin
            if (load) begin
                m_tvalid_reg  <= 1'b1;
                pair_half_reg <= head_entry.pair && !pair_half_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Load result fields; the second half of a pair is finished-empty
    always_ff @(posedge aclk) begin
        if (load) begin
            if (pair_half_reg) begin
                kind_reg <= ffd_pkg::KIND_EMPTY;
                byte_reg <= '0;
                last_reg <= 1'b0;
                type_reg <= '0;
                size_reg <= '0;
            end else begin
                kind_reg <= head_entry.kind;
                byte_reg <= head_entry.byte_value;
                last_reg <= head_entry.is_last;
                type_reg <= head_entry.frame_type;
                size_reg <= head_entry.payload_size;
            end
        end
    end

    a_half_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        pair_half_reg |-> m_tvalid_reg)
        else $error("pair half pending without the started result on show");

    a_half_started: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(pair_half_reg) |-> (kind_reg == ffd_pkg::KIND_STARTED && size_reg == '0))
        else $error("pair did not open with an empty started result");

    a_half_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && pair_half_reg) |=> (kind_reg == ffd_pkg::KIND_EMPTY && !pair_half_reg))
        else $error("second half of a pair is not finished-empty");

endmodule

`default_nettype wire

// File: sv/file_frame_deframer.sv
// Top level of the file frame deframer: parser, request queue and output stage.
// Depends on ffd_pkg, ffd_front, ffd_queue and ffd_back.
`timescale 1ns / 1ps
`default_nettype none

// Parses a length-prefixed file frame one byte per clock: type word, name length,
// name bytes, 64-bit size, payload bytes. Each accepted byte leaves at most one
// request in a four-entry queue; bytes are accepted only while it is not full. The
// output register shows results one per cycle while m_tready is high, so a stream
// runs at one byte per clock when neither stalls. A zero-size frame gives two results
// (started, then finished empty), which the queue absorbs. An abort (tuser high)
// returns the parser to the header and gives no result.
module file_frame_deframer (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [ffd_pkg::NAME_LEN_W-1:0]         cfg_wr_data,   // max_name_length
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [7:0]                             s_tdata,       // [7:0] data_byte
    input  wire logic [0:0]                             s_tuser,       // [0] action
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // [7:0] byte_value, [39:8] frame_type, [102:40] payload_size, [103] zero
    output logic [ffd_pkg::TDATA_OUT_W-1:0]             m_tdata,
    output logic [2:0]                                  m_tuser,       // [2:0] kind
    output logic                                        m_tlast        // is_last
);

    logic               q_full;
    logic               push;
    ffd_pkg::entry_t    push_entry;
    logic               pop;
    logic               head_valid;
    ffd_pkg::entry_t    head_entry;

    ffd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_action   (s_tuser[0]),
        .in_byte     (s_tdata),
        .in_ready    (s_tready),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    ffd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    ffd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
